@@ rtl/core/lbcf_pkg.sv @@
// shared types and constants for the largest blob center finder
package lbcf_pkg;

   localparam int DEFAULT_LINE_PIXELS = 128;

   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CENTER_W    = 8;
   localparam int GAP_W       = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_VALUE = 2'd0,
      CSR_GAP_LIMIT    = 2'd1,
      CSR_MIN_WIDTH    = 2'd2
   } csr_index_type;

   localparam logic signed [1:0] TARGET_VALUE_RESET = 2'sd1;
   localparam logic [6:0]        GAP_LIMIT_RESET    = 7'd0;
   localparam logic [6:0]        MIN_WIDTH_RESET    = 7'd0;

   // reported when no run was kept or the center lands on zero
   localparam logic signed [CENTER_W-1:0] NO_CENTER = -8'sd1;

   typedef struct packed {
      logic signed [1:0] target_value;
      logic [6:0]        gap_limit;
      logic [6:0]        min_width;
   } cfg_type;

   typedef struct packed {
      logic                        valid;
      logic signed [CENTER_W-1:0]  center;
   } result_type;

endpackage

@@ rtl/core/lbcf_csr.sv @@
// configuration registers of the blob center finder
module lbcf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [lbcf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lbcf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output lbcf_pkg::cfg_type                  cfg
);

   lbcf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lbcf_pkg::CSR_TARGET_VALUE: cfg_in.target_value = csr_wdata[1:0];
            lbcf_pkg::CSR_GAP_LIMIT:    cfg_in.gap_limit    = csr_wdata[6:0];
            lbcf_pkg::CSR_MIN_WIDTH:    cfg_in.min_width    = csr_wdata[6:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_value <= lbcf_pkg::TARGET_VALUE_RESET;
         cfg_ff.gap_limit    <= lbcf_pkg::GAP_LIMIT_RESET;
         cfg_ff.min_width    <= lbcf_pkg::MIN_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/lbcf_run_tracker.sv @@
// per-pixel run tracking and end-of-line center computation
module lbcf_run_tracker #(
   parameter int LINE_PIXELS = lbcf_pkg::DEFAULT_LINE_PIXELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lbcf_pkg::cfg_type     cfg,
   input  logic                  pixel_accept,
   input  logic signed [1:0]     pixel_class,
   input  logic                  end_of_line,
   output lbcf_pkg::result_type  result
);

   localparam int POS_W = (LINE_PIXELS > 2) ? $clog2(LINE_PIXELS) : 1;
   localparam int EXT_W = (POS_W > lbcf_pkg::CENTER_W) ? POS_W : lbcf_pkg::CENTER_W;
   localparam int CMP_W = (POS_W > 7) ? POS_W : 7;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_PIXELS - 1);

   typedef struct packed {
      logic                          in_run;
      logic [lbcf_pkg::GAP_W-1:0]    gap_count;
      logic [POS_W-1:0]              pos;
      logic [POS_W-1:0]              run_first;
      logic [POS_W-1:0]              run_latest;
      logic [POS_W-1:0]              best_first;
      logic [POS_W-1:0]              best_latest;
   } track_type;

   track_type st_ff, st_in, st_a, st_eol;

   logic            match;
   logic [POS_W:0]  center_sum;
   logic [POS_W-1:0] center;
   logic [EXT_W-1:0] center_ext;

   // keeps the candidate run if wide enough and strictly wider than the best
   function automatic track_type judge(input track_type s, input logic [6:0] min_w);
      track_type        r;
      logic [POS_W-1:0] w;
      logic [POS_W-1:0] bw;
      r  = s;
      w  = s.run_latest - s.run_first;
      bw = s.best_latest - s.best_first;
      if ((CMP_W'(w) > CMP_W'(min_w)) && (bw < w)) begin
         r.best_first  = s.run_first;
         r.best_latest = s.run_latest;
      end
      return r;
   endfunction

   assign match = (pixel_class == cfg.target_value);

   always_comb begin
      st_a = st_ff;
      if (match) begin
         st_a.in_run     = 1'b1;
         if (!st_ff.in_run) st_a.run_first = st_ff.pos;
         st_a.gap_count  = '0;
         st_a.run_latest = st_ff.pos;
      end else if (st_ff.in_run) begin
         if (st_ff.gap_count > {1'b0, cfg.gap_limit}) begin
            st_a            = judge(st_ff, cfg.min_width);
            st_a.run_first  = '0;
            st_a.run_latest = '0;
            st_a.in_run     = 1'b0;
         end else begin
            st_a.gap_count = st_ff.gap_count + 1'b1;
         end
      end
      // an open run is judged on the last pixel of the line
      if (st_a.in_run) st_eol = judge(st_a, cfg.min_width);
      else st_eol = st_a;
      st_in = st_a;
      if (st_ff.pos < LAST_POS) st_in.pos = st_ff.pos + 1'b1;
      if (end_of_line) st_in = '0;
   end

   assign center_sum = {1'b0, st_eol.best_first} + {1'b0, st_eol.best_latest};
   assign center     = center_sum[POS_W:1];
   assign center_ext = EXT_W'(center);

   always_comb begin
      result.valid = pixel_accept && end_of_line;
      if (center == '0) result.center = lbcf_pkg::NO_CENTER;
      else result.center = center_ext[lbcf_pkg::CENTER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (pixel_accept) begin
         st_ff <= st_in;
      end
   end

endmodule

@@ rtl/core/lbcf_out_reg.sv @@
// result holding register toward the receiver
module lbcf_out_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  lbcf_pkg::result_type                result,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [lbcf_pkg::CENTER_W-1:0] rsp_center_index
);

   logic                                 valid_ff, valid_in;
   logic signed [lbcf_pkg::CENTER_W-1:0] center_ff;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if (result.valid) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (result.valid) center_ff <= result.center;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_center_index = center_ff;

endmodule

@@ rtl/core/largest_blob_center_finder.sv @@
// top level of the largest blob center finder
// Usage:
//   req_ channel carries one thresholded pixel per item (req_pixel_class,
//   req_end_of_line marks the last pixel of a scan line).
//   rsp_ channel carries one item per line: rsp_center_index, the center
//   of the widest qualifying run of target pixels, or -1 for none or zero.
//   csr_ port writes target_value, gap_limit and min_width; write only
//   while no line is in flight.
// Throughput: one pixel per cycle while no end-of-line item is stalled (see
//   Stall); the run state updates in the same cycle the pixel is taken, in a single compare and update step.
// Output: the center is held in a one-entry register and is presented in the
//   cycle after the end-of-line item is accepted, then updated again only
//   by a later end-of-line item.
// Stall: while a result waits, pixels without end_of_line are still taken;
//   an end-of-line item waits until the slot frees, and can enter in the
//   cycle the pending result is taken.
// Reset: synchronous; clears the run state and the result slot and loads
//   target_value 1, gap_limit 0, min_width 0.
module largest_blob_center_finder #(
   parameter int LINE_PIXELS = lbcf_pkg::DEFAULT_LINE_PIXELS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [1:0]                    req_pixel_class,
   input  logic                                 req_end_of_line,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lbcf_pkg::CENTER_W-1:0] rsp_center_index,
   input  logic                                 csr_write_enable,
   input  logic [lbcf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lbcf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lbcf_pkg::cfg_type    cfg;
   lbcf_pkg::result_type result;
   logic                 pixel_accept;

   // only an end-of-line item needs the result slot
   assign req_ready    = !rsp_valid || rsp_ready || !req_end_of_line;
   assign pixel_accept = req_valid && req_ready;

   lbcf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   lbcf_run_tracker #(
      .LINE_PIXELS (LINE_PIXELS)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .pixel_accept (pixel_accept),
      .pixel_class  (req_pixel_class),
      .end_of_line  (req_end_of_line),
      .result       (result)
   );

   lbcf_out_reg u_out (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_center_index (rsp_center_index)
   );

endmodule

@@ tb/tb_largest_blob_center_finder.sv @@
// testbench for the largest blob center finder: scan lines in, widest-run centers checked
`timescale 1ns / 100ps

module tb_largest_blob_center_finder;

   localparam int LINE_PIXELS   = lbcf_pkg::DEFAULT_LINE_PIXELS;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_PCT      = 37;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS  = 900;
   localparam int MIN_LINES     = 40;
   localparam int PHASE_ITEMS   = 80;
   // watchdog limit for stretches with no handshake and no csr write; the run then fails
   localparam int STALL_LIMIT   = 2000;

   localparam logic [1:0] NEUTRAL = 2'b00;
   localparam logic [1:0] BRIGHT  = 2'b01;
   localparam logic [1:0] WRAPPED = 2'b10;
   localparam logic [1:0] DARK    = 2'b11;

   logic                                  clock            = 1'b0;
   logic                                  reset            = 1'b1;
   logic                                  req_valid        = 1'b0;
   logic                                  req_ready;
   logic signed [1:0]                     req_pixel_class  = 2'sd0;
   logic                                  req_end_of_line  = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready        = 1'b0;
   logic signed [lbcf_pkg::CENTER_W-1:0]  rsp_center_index;
   logic                                  csr_write_enable = 1'b0;
   logic [lbcf_pkg::CSR_INDEX_W-1:0]      csr_index        = '0;
   logic [lbcf_pkg::CSR_DATA_W-1:0]       csr_wdata        = '0;

   // scan predictor: settings and per-line run state
   logic [1:0] cfg_target     = lbcf_pkg::TARGET_VALUE_RESET;
   logic [6:0] cfg_gap_limit  = lbcf_pkg::GAP_LIMIT_RESET;
   logic [6:0] cfg_min_width  = lbcf_pkg::MIN_WIDTH_RESET;
   bit         scan_in_run;
   logic [7:0] scan_gap;
   logic [6:0] scan_pos;
   logic [6:0] run_start;
   logic [6:0] run_end;
   logic [6:0] best_start;
   logic [6:0] best_end;

   logic signed [lbcf_pkg::CENTER_W-1:0] expected_centers[$];
   int  mismatch_count = 0;
   int  stall_cycles   = 0;
   int  random_items   = 0;
   int  random_lines   = 0;
   bit  steady_mode    = 1'b0;

   largest_blob_center_finder #(.LINE_PIXELS(LINE_PIXELS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_class (req_pixel_class),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_center_index(rsp_center_index),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic void clear_scan();
      scan_in_run = 1'b0;
      scan_gap    = '0;
      scan_pos    = '0;
      run_start   = '0;
      run_end     = '0;
      best_start  = '0;
      best_end    = '0;
   endfunction

   function automatic void keep_if_widest();
      int run_width;
      int best_width;
      run_width  = int'(run_end) - int'(run_start);
      best_width = int'(best_end) - int'(best_start);
      if (run_width > int'(cfg_min_width) && best_width < run_width) begin
         best_start = run_start;
         best_end   = run_end;
      end
   endfunction

   function automatic void advance_scan(input logic [1:0] pix, input logic eol);
      int centre;
      if (pix == cfg_target) begin
         if (!scan_in_run) begin
            scan_in_run = 1'b1;
            run_start   = scan_pos;
         end
         scan_gap = '0;
         run_end  = scan_pos;
      end else if (scan_in_run) begin
         if (scan_gap > {1'b0, cfg_gap_limit}) begin
            keep_if_widest();
            run_start   = '0;
            run_end     = '0;
            scan_in_run = 1'b0;
         end else begin
            scan_gap = scan_gap + 8'd1;
         end
      end
      if (!eol) begin
         // position sticks at the last index on overlong lines
         if (int'(scan_pos) < LINE_PIXELS - 1)
            scan_pos = scan_pos + 7'd1;
      end else begin
         if (scan_in_run)
            keep_if_widest();
         centre = (int'(best_start) + int'(best_end)) / 2;
         expected_centers.push_back(centre == 0 ? lbcf_pkg::NO_CENTER
                                                : lbcf_pkg::CENTER_W'(centre));
         clear_scan();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // result side: random backpressure outside steady mode, compare against the oldest expected center
   always @(posedge clock) begin
      logic signed [lbcf_pkg::CENTER_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_centers.size() == 0) begin
            report_mismatch($sformatf("center %0d with no line pending", rsp_center_index));
         end else begin
            want = expected_centers.pop_front();
            if (rsp_center_index !== want)
               report_mismatch($sformatf("center_index got %0d expected %0d",
                                         rsp_center_index, want));
         end
      end
      rsp_ready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL largest_blob_center_finder");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [1:0] pix, input logic eol);
      while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_class <= pix;
      req_end_of_line <= eol;
      do @(posedge clock); while (!req_ready);
      advance_scan(pix, eol);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_centers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [1:0] target, input logic [6:0] gap,
                                input logic [6:0] minw);
      csr_write_enable <= 1'b1;
      csr_index        <= lbcf_pkg::CSR_TARGET_VALUE;
      csr_wdata        <= {5'($urandom), target};
      @(posedge clock);
      csr_index        <= lbcf_pkg::CSR_GAP_LIMIT;
      csr_wdata        <= gap;
      @(posedge clock);
      csr_index        <= lbcf_pkg::CSR_MIN_WIDTH;
      csr_wdata        <= minw;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_target    = target;
      cfg_gap_limit = gap;
      cfg_min_width = minw;
   endtask

   function automatic logic [1:0] pick_pixel(input int density);
      if ($urandom_range(99) < density)
         return cfg_target;
      return 2'($urandom_range(3));
   endfunction

   task automatic send_line(input int length, input int density);
      for (int i = 0; i < length; i++)
         send_pixel(pick_pixel(density), i == length - 1);
   endtask

   task automatic test_basic_runs();
      load_settings(BRIGHT, 7'd0, 7'd0);
      // lone pixel: zero-width run is never kept
      send_pixel(BRIGHT, 1'b1);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(BRIGHT, 1'b0);
      send_pixel(BRIGHT, 1'b0);
      send_pixel(BRIGHT, 1'b1);
      // run at 0..1 has center zero, reported as none
      send_pixel(BRIGHT, 1'b0);
      send_pixel(BRIGHT, 1'b1);
      drain_results();
   endtask

   task automatic test_odd_targets();
      // the -2 pattern as target and as pixel
      load_settings(WRAPPED, 7'd1, 7'd1);
      send_pixel(WRAPPED, 1'b0);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(WRAPPED, 1'b0);
      send_pixel(WRAPPED, 1'b0);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(DARK, 1'b1);
      drain_results();
      load_settings(NEUTRAL, 7'd127, 7'd127);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(BRIGHT, 1'b1);
      drain_results();
      load_settings(DARK, 7'd0, 7'd0);
      send_pixel(DARK, 1'b0);
      send_pixel(DARK, 1'b0);
      send_pixel(NEUTRAL, 1'b0);
      send_pixel(DARK, 1'b0);
      send_pixel(WRAPPED, 1'b1);
      drain_results();
   endtask

   task automatic test_random_lines();
      int         phase;
      int         phase_items;
      int         length;
      logic [1:0] target;
      logic [6:0] gap;
      logic [6:0] minw;
      phase = 0;
      while (random_items < RANDOM_ITEMS || random_lines < MIN_LINES) begin
         case (phase % 4)
            0:       target = BRIGHT;
            1:       target = DARK;
            2:       target = WRAPPED;
            default: target = NEUTRAL;
         endcase
         case (phase)
            1:       gap = 7'd127;
            2:       gap = 7'd0;
            default: gap = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(6));
         endcase
         case (phase)
            2:       minw = 7'd0;
            3:       minw = 7'd127;
            default: minw = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                                    : 7'($urandom_range(8));
         endcase
         drain_results();
         load_settings(target, gap, minw);
         steady_mode = (phase == 5);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // now and then a line past the end of the sensor
            length = (random_lines % 16 == 5) ? $urandom_range(200, 129) : $urandom_range(24, 1);
            send_line(length, $urandom_range(95, 20));
            phase_items  += length;
            random_items += length;
            random_lines++;
            if (random_lines % 7 == 3)
               drain_results();
         end
         phase++;
      end
      steady_mode = 1'b0;
   endtask

   initial begin
      clear_scan();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_runs();
      test_odd_targets();
      test_random_lines();
      drain_results();
      if (mismatch_count == 0) begin
         $display("PASS largest_blob_center_finder");
      end else begin
         $display("FAIL largest_blob_center_finder");
      end
      $finish;
   end

endmodule
